FILE: design/bitvector_alu_defines.svh
// assertion macros shared by the bitvector alu modules
// depends on nothing; users provide i_clk and i_rst_n in scope
`ifndef BITVECTOR_ALU_DEFINES_SVH
`define BITVECTOR_ALU_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BVA_AST_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("bitvector_alu assertion failed");

// next-cycle implication, disabled while in reset
`define BVA_AST_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("bitvector_alu assertion failed");

`endif

FILE: design/bva_pkg.sv
// shared types and constants of the bitvector alu
// no dependencies
`timescale 1ns / 1ps

package bva_pkg;

    localparam int WIDTH   = 32;
    localparam int OP_W    = 5;
    localparam int SH_W    = $clog2(WIDTH);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_NOT  = 5'd0,
        OP_AND  = 5'd1,
        OP_OR   = 5'd2,
        OP_XOR  = 5'd3,
        OP_EQ   = 5'd4,
        OP_ULT  = 5'd5,
        OP_SLT  = 5'd6,
        OP_ADD  = 5'd7,
        OP_NEG  = 5'd8,
        OP_SUB  = 5'd9,
        OP_MUL  = 5'd10,
        OP_SHL  = 5'd11,
        OP_SHR  = 5'd12,
        OP_ASHR = 5'd13,
        OP_UDIV = 5'd14,
        OP_UREM = 5'd15,
        OP_SEL  = 5'd16
    } t_op;

    // which result the back end delivers
    typedef enum logic [1:0] {
        CLS_ALU = 2'd0,
        CLS_DIV = 2'd1,
        CLS_REM = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic [OP_W-1:0]  op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic             cond;
    } t_entry;

    // queue head offered to the back end
    typedef struct packed {
        logic   vld;
        t_entry ent;
    } t_head;

endpackage

FILE: design/bva_if.sv
// request and response channel interfaces of the bitvector alu
// depends on bva_pkg
`timescale 1ns / 1ps

interface bva_req_if;
    logic                      valid;
    logic                      ready;
    logic [bva_pkg::OP_W-1:0]  req_type;
    logic [bva_pkg::WIDTH-1:0] operand_a;
    logic [bva_pkg::WIDTH-1:0] operand_b;
    logic                      select_cond;

    modport source (output valid, req_type, operand_a, operand_b, select_cond,
                    input ready);
    modport sink (input valid, req_type, operand_a, operand_b, select_cond,
                  output ready);
endinterface

interface bva_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bva_pkg::WIDTH-1:0] result;

    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

FILE: design/bva_front.sv
// front end: accepts request transactions, classifies them, and queues them
// depends on bva_pkg, bva_if and bitvector_alu_defines.svh
`timescale 1ns / 1ps
`include "bitvector_alu_defines.svh"

module bva_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bva_req_if.sink         i_req,
    input  logic            i_pop,
    output bva_pkg::t_head  o_head
);

    localparam int Q_DEPTH_L = bva_pkg::Q_DEPTH;

    bva_pkg::t_entry                r_mem [Q_DEPTH_L];
    logic [bva_pkg::Q_PTR_W-1:0]    r_wr, n_wr;
    logic [bva_pkg::Q_PTR_W-1:0]    r_rd, n_rd;
    logic [bva_pkg::Q_CNT_W-1:0]    r_cnt, n_cnt;
    bva_pkg::t_entry                w_ent;
    logic                           w_push;
    logic                           w_pop;

    // classify the incoming transaction
    always_comb begin
        w_ent.op   = i_req.req_type;
        w_ent.a    = i_req.operand_a;
        w_ent.b    = i_req.operand_b;
        w_ent.cond = i_req.select_cond;
        case (i_req.req_type)
            bva_pkg::OP_UDIV: w_ent.cls = bva_pkg::CLS_DIV;
            bva_pkg::OP_UREM: w_ent.cls = bva_pkg::CLS_REM;
            default:          w_ent.cls = bva_pkg::CLS_ALU;
        endcase
    end

    assign i_req.ready = (r_cnt != bva_pkg::Q_CNT_W'(bva_pkg::Q_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_cnt != '0);

    // queue pointers and fill count
    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + bva_pkg::Q_CNT_W'(w_push) - bva_pkg::Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_ent;
        end
    end

    assign o_head.vld = (r_cnt != '0);
    assign o_head.ent = r_mem[r_rd];

    `BVA_AST_SAME(a_cnt_bound, 1'b1, r_cnt <= bva_pkg::Q_CNT_W'(bva_pkg::Q_DEPTH))
    `BVA_AST_NEXT(a_cnt_up, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1)
    `BVA_AST_NEXT(a_cnt_dn, w_pop && !w_push, r_cnt == $past(r_cnt) - 1'b1)

endmodule

FILE: design/bva_back.sv
// back end: executes queued operations in a pipeline with a radix-2 divider
// depends on bva_pkg, bva_if and bitvector_alu_defines.svh
`timescale 1ns / 1ps
`include "bitvector_alu_defines.svh"

module bva_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bva_pkg::t_head  i_head,
    output logic            o_pop,
    bva_rsp_if.source       o_rsp
);

    localparam int W = bva_pkg::WIDTH;

    typedef struct packed {
        bva_pkg::t_cls cls;
        logic [W-1:0]  res;
        logic [W-1:0]  rem;
        logic [W-1:0]  quo;
        logic [W-1:0]  dvs;
    } t_stage;

    t_stage         r_stg [W+1];
    t_stage         n_stg [W+1];
    logic [W:0]     r_vld;
    logic           r_ovld;
    logic [W-1:0]   r_odata;
    logic           w_en;
    logic [W-1:0]   w_alu;
    logic [W-1:0]   w_prod;
    logic           w_big;
    logic [W-1:0]   w_a;
    logic [W-1:0]   w_b;

    // whole pipeline advances when the output register frees up
    assign w_en  = !r_ovld || o_rsp.ready;
    assign o_pop = w_en && i_head.vld;

    assign w_a    = i_head.ent.a;
    assign w_b    = i_head.ent.b;
    assign w_prod = w_a * w_b;
    assign w_big  = (w_b >= W'(W));

    // combinational operations (all but divide and remainder)
    always_comb begin
        case (i_head.ent.op)
            bva_pkg::OP_NOT:  w_alu = ~w_a;
            bva_pkg::OP_AND:  w_alu = w_a & w_b;
            bva_pkg::OP_OR:   w_alu = w_a | w_b;
            bva_pkg::OP_XOR:  w_alu = w_a ^ w_b;
            bva_pkg::OP_EQ:   w_alu = W'(w_a == w_b);
            bva_pkg::OP_ULT:  w_alu = W'(w_a < w_b);
            bva_pkg::OP_SLT:  w_alu = W'($signed(w_a) < $signed(w_b));
            bva_pkg::OP_ADD:  w_alu = w_a + w_b;
            bva_pkg::OP_NEG:  w_alu = '0 - w_a;
            bva_pkg::OP_SUB:  w_alu = w_a - w_b;
            bva_pkg::OP_MUL:  w_alu = w_prod;
            bva_pkg::OP_SHL:  w_alu = w_big ? '0 : w_a << w_b[bva_pkg::SH_W-1:0];
            bva_pkg::OP_SHR:  w_alu = w_big ? '0 : w_a >> w_b[bva_pkg::SH_W-1:0];
            bva_pkg::OP_ASHR: w_alu = w_big ? {W{w_a[W-1]}}
                                     : W'($signed(w_a) >>> w_b[bva_pkg::SH_W-1:0]);
            bva_pkg::OP_SEL:  w_alu = i_head.ent.cond ? w_a : w_b;
            default:          w_alu = '0;
        endcase
    end

    // stage zero loads, stages one to W each resolve one quotient bit
    always_comb begin
        logic [W:0] rsh;
        logic [W:0] dif;
        n_stg[0].cls = i_head.ent.cls;
        n_stg[0].res = w_alu;
        n_stg[0].rem = '0;
        n_stg[0].quo = w_a;
        n_stg[0].dvs = w_b;
        for (int k = 1; k <= W; k++) begin
            rsh = {r_stg[k-1].rem, r_stg[k-1].quo[W-1]};
            dif = rsh - {1'b0, r_stg[k-1].dvs};
            n_stg[k]     = r_stg[k-1];
            n_stg[k].rem = dif[W] ? rsh[W-1:0] : dif[W-1:0];
            n_stg[k].quo = {r_stg[k-1].quo[W-2:0], !dif[W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[W-1:0], i_head.vld};
            r_ovld <= r_vld[W];
        end
    end

    // payload stages and output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= W; k++) begin
                r_stg[k] <= n_stg[k];
            end
            case (r_stg[W].cls)
                bva_pkg::CLS_DIV: r_odata <= r_stg[W].quo;
                bva_pkg::CLS_REM: r_odata <= r_stg[W].rem;
                default:          r_odata <= r_stg[W].res;
            endcase
        end
    end

    assign o_rsp.valid  = r_ovld;
    assign o_rsp.result = r_odata;

    `BVA_AST_NEXT(a_out_hold, r_ovld && !o_rsp.ready, r_ovld && $stable(r_odata))
    `BVA_AST_NEXT(a_last_moves, r_vld[W] && w_en, r_ovld)
    `BVA_AST_SAME(a_div_zero, r_vld[W] && r_stg[W].dvs == '0, r_stg[W].quo == '1)

endmodule

FILE: design/bitvector_alu.sv
// top level of the bitvector alu: front end queue feeding the execution pipeline
// depends on bva_pkg, bva_if, bva_front and bva_back
`timescale 1ns / 1ps

// Bitvector ALU. Each request transaction carries an opcode, two 32-bit
// operands and a select condition, and produces exactly one response in
// request order. A new request is taken every cycle while the four-entry
// queue has room; every operation passes through the same WIDTH+2 stage
// execution pipeline (one load stage, one stage per quotient bit of the
// restoring divider, one output register) from queue head to response.
// Backpressure on the response holds the whole pipeline; the queue then
// absorbs up to four more requests.

module bitvector_alu (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bva_req_if.sink  i_req,
    bva_rsp_if.source o_rsp
);

    bva_pkg::t_head w_head;
    logic           w_pop;

    bva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    bva_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: tb/bitvector_alu_tb.sv
// self-checking testbench of the bitvector alu: directed table then random operations
// depends on bva_pkg, bva_if and the bitvector_alu design
`timescale 1ns / 1ps

module bitvector_alu_tb;
    import bva_pkg::*;

    localparam int N_RANDOM = 1600;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic             cond;
        logic             known;
        logic [WIDTH-1:0] res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    bva_req_if req_ch ();
    bva_rsp_if rsp_ch ();

    bitvector_alu dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    logic [WIDTH-1:0] pending_results[$];
    int               n_errors;
    bit               sending_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // computes the expected alu result of one operation
    function automatic logic [WIDTH-1:0] alu_result(logic [OP_W-1:0] op,
                                                    logic [WIDTH-1:0] a,
                                                    logic [WIDTH-1:0] b,
                                                    logic cond);
        logic [WIDTH-1:0] r;
        r = '0;
        case (op)
            OP_NOT:  r = ~a;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_EQ:   r = WIDTH'(a == b);
            OP_ULT:  r = WIDTH'(a < b);
            OP_SLT:  r = WIDTH'($signed(a) < $signed(b));
            OP_ADD:  r = a + b;
            OP_NEG:  r = -a;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_SHL:  r = (b >= WIDTH) ? '0 : a << b;
            OP_SHR:  r = (b >= WIDTH) ? '0 : a >> b;
            OP_ASHR: r = (b >= WIDTH) ? {WIDTH{a[WIDTH-1]}} : WIDTH'($signed(a) >>> b);
            OP_UDIV: r = (b == 0) ? '1 : a / b;
            OP_UREM: r = (b == 0) ? a : a % b;
            OP_SEL:  r = cond ? a : b;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(0, 40);
            5:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // drives one request transaction after a random gap; valid stays high after
    // acceptance so that back-to-back transactions leave no idle gap
    task automatic send_op(logic [OP_W-1:0] op, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                           logic cond);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(0, 2));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= op;
        req_ch.operand_a   <= a;
        req_ch.operand_b   <= b;
        req_ch.select_cond <= cond;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(alu_result(op, a, b, cond));
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        logic [WIDTH-1:0] ra, rb;
        logic [OP_W-1:0]  rop;
        n_errors = 0;
        sending_done = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = OP_NOT;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        req_ch.select_cond = 1'b0;
        rows = '{
            '{OP_NOT,  32'h0,          32'h0,          1'b0, 1'b1, 32'hffff_ffff},
            '{OP_AND,  32'hffff_ffff,  32'hffff_ffff,  1'b0, 1'b1, 32'hffff_ffff},
            '{OP_OR,   32'h0,          32'h0,          1'b0, 1'b1, 32'h0},
            '{OP_XOR,  32'hffff_ffff,  32'h0,          1'b1, 1'b1, 32'hffff_ffff},
            '{OP_EQ,   32'h1234_5678,  32'h1234_5678,  1'b0, 1'b1, 32'h1},
            '{OP_ULT,  32'h0,          32'hffff_ffff,  1'b0, 1'b1, 32'h1},
            '{OP_SLT,  32'h0,          32'hffff_ffff,  1'b0, 1'b1, 32'h0},
            '{OP_SLT,  32'h8000_0000,  32'h7fff_ffff,  1'b0, 1'b1, 32'h1},
            '{OP_ADD,  32'hffff_ffff,  32'h1,          1'b0, 1'b1, 32'h0},
            '{OP_NEG,  32'h1,          32'hdead_beef,  1'b0, 1'b1, 32'hffff_ffff},
            '{OP_SUB,  32'h0,          32'h1,          1'b0, 1'b1, 32'hffff_ffff},
            '{OP_MUL,  32'hffff_ffff,  32'hffff_ffff,  1'b0, 1'b1, 32'h1},
            '{OP_SHL,  32'hffff_ffff,  32'd32,         1'b0, 1'b1, 32'h0},
            '{OP_SHL,  32'h1,          32'd31,         1'b0, 1'b1, 32'h8000_0000},
            '{OP_SHR,  32'hffff_ffff,  32'hffff_ffff,  1'b0, 1'b1, 32'h0},
            '{OP_ASHR, 32'h8000_0000,  32'd40,         1'b0, 1'b1, 32'hffff_ffff},
            '{OP_ASHR, 32'h7fff_ffff,  32'd32,         1'b0, 1'b1, 32'h0},
            '{OP_ASHR, 32'h8000_0000,  32'd4,          1'b0, 1'b0, 32'h0},
            '{OP_UDIV, 32'h1234_5678,  32'h0,          1'b0, 1'b1, 32'hffff_ffff},
            '{OP_UREM, 32'h1234_5678,  32'h0,          1'b0, 1'b1, 32'h1234_5678},
            '{OP_UDIV, 32'hffff_ffff,  32'h7,          1'b0, 1'b0, 32'h0},
            '{OP_SEL,  32'haaaa_aaaa,  32'h5555_5555,  1'b1, 1'b1, 32'haaaa_aaaa},
            '{OP_SEL,  32'haaaa_aaaa,  32'h5555_5555,  1'b0, 1'b1, 32'h5555_5555},
            '{5'd17,   32'hffff_ffff,  32'hffff_ffff,  1'b1, 1'b1, 32'h0},
            '{5'd31,   32'hffff_ffff,  32'hffff_ffff,  1'b0, 1'b1, 32'h0}
        };
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; typed-in results of rows marked known are checked against the predictor too
        foreach (rows[i]) begin
            row = rows[i];
            if (row.known && alu_result(row.op, row.a, row.b, row.cond) !== row.res) begin
                $display("%0t: table row %0d expected %h actual %h", $time, i, row.res,
                         alu_result(row.op, row.a, row.b, row.cond));
                n_errors++;
            end
            send_op(row.op, row.a, row.b, row.cond);
        end

        // random operations, unused codes now and then
        for (int i = 0; i < N_RANDOM; i++) begin
            rop = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(17, 31))
                                               : OP_W'($urandom_range(0, 16));
            ra = rand_operand();
            rb = rand_operand();
            if (rop inside {OP_SHL, OP_SHR, OP_ASHR} && $urandom_range(0, 3) != 0)
                rb = $urandom_range(0, 33);
            send_op(rop, ra, rb, 1'($urandom));
        end
        req_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // response sink with random stalls
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(0, 3);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        logic [WIDTH-1:0] want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, expected none actual %h", $time,
                         rsp_ch.result);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.result !== want) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want,
                             rsp_ch.result);
                    n_errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (sending_done);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
